// File: rtl/srb_pkg.sv
// shared constants, result type and kind codes for the sequence reorder buffer
// no dependencies
package srb_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int CMD_BITS     = 64;
    localparam int DATA_BITS    = 64;
    localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        KIND_RELEASED = 2'd0,
        KIND_BUFFERED = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [DATA_BITS-1:0] command;
        logic [DATA_BITS-1:0] seq;
        logic                 last;
    } result_t;

endpackage

// File: rtl/srb_if.sv
// valid/ready channel interfaces for command input and result output
// depends on srb_pkg
interface srb_in_if;
    logic                         valid;
    logic                         ready;
    logic [srb_pkg::DATA_BITS-1:0] seq_num;
    logic [srb_pkg::DATA_BITS-1:0] command;

    modport source (output valid, output seq_num, output command, input ready);
    modport sink   (input valid, input seq_num, input command, output ready);
endinterface

interface srb_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [srb_pkg::DATA_BITS-1:0] out_command;
    logic [srb_pkg::DATA_BITS-1:0] out_seq;
    logic                         last;

    modport source (output valid, output kind, output out_command, output out_seq,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_command, input out_seq,
                    input last, output ready);
endinterface

// File: rtl/srb_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/srb_out_reg.sv
// output register stage: holds one result until the sink takes it
// depends on srb_pkg, srb_if
module srb_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  srb_pkg::result_t  result,
    output logic              out_free,
    srb_out_if.source         rsp
);

    logic             valid_reg;
    logic             valid_next;
    srb_pkg::result_t result_reg;

    assign out_free   = !valid_reg || rsp.ready;
    assign valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.kind        = result_reg.kind;
    assign rsp.out_command = result_reg.command;
    assign rsp.out_seq     = result_reg.seq;
    assign rsp.last        = result_reg.last;

endmodule

// File: rtl/srb_seq_ctrl.sv
// sequencer: head counter, slot valid bits, classification and release run
// depends on srb_pkg, srb_if; drives the slot ram ports
module srb_seq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    srb_in_if.sink                        req,
    input  logic                          out_free,
    output logic                          res_load,
    output srb_pkg::result_t              result,
    output logic                          ram_wr_en,
    output logic [srb_pkg::IDX_BITS-1:0]  ram_wr_addr,
    output logic [srb_pkg::CMD_BITS-1:0]  ram_wr_data,
    output logic                          ram_rd_en,
    output logic [srb_pkg::IDX_BITS-1:0]  ram_rd_addr,
    input  logic [srb_pkg::CMD_BITS-1:0]  ram_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [srb_pkg::DATA_BITS-1:0]        head_reg;
    logic [srb_pkg::DATA_BITS-1:0]        head_next;
    logic [srb_pkg::IDX_BITS-1:0]         head_idx_reg;
    logic [srb_pkg::IDX_BITS-1:0]         head_idx_next;
    logic [srb_pkg::WINDOW_DEPTH-1:0]     valid_reg;
    logic [srb_pkg::WINDOW_DEPTH-1:0]     valid_next;
    logic [srb_pkg::DATA_BITS-1:0]        seq_reg;
    logic [srb_pkg::CMD_BITS-1:0]         cmd_reg;

    logic [srb_pkg::DATA_BITS-1:0]        diff;
    logic                                 behind;
    logic                                 far;
    logic                                 reject;
    logic [srb_pkg::IDX_BITS:0]           idx_sum;
    logic [srb_pkg::IDX_BITS-1:0]         buf_idx;
    logic [srb_pkg::IDX_BITS-1:0]         next_idx;
    logic                                 run_last;

    // classification of the captured command against the head
    assign diff   = seq_reg - head_reg;
    assign behind = seq_reg < head_reg;
    assign far    = diff >= srb_pkg::DATA_BITS'(srb_pkg::WINDOW_DEPTH);
    assign reject = (cmd_reg == '0) || behind || far;

    // slot index = (head index + distance) mod depth, distance below depth
    assign idx_sum = {1'b0, head_idx_reg} + {1'b0, diff[srb_pkg::IDX_BITS-1:0]};
    assign buf_idx = (idx_sum >= (srb_pkg::IDX_BITS+1)'(srb_pkg::WINDOW_DEPTH))
                   ? srb_pkg::IDX_BITS'(idx_sum - (srb_pkg::IDX_BITS+1)'(srb_pkg::WINDOW_DEPTH))
                   : idx_sum[srb_pkg::IDX_BITS-1:0];

    assign next_idx = (head_idx_reg == srb_pkg::IDX_BITS'(srb_pkg::WINDOW_DEPTH - 1))
                    ? '0 : head_idx_reg + 1'b1;
    assign run_last = !valid_reg[next_idx];

    assign req.ready   = (state_reg == ST_IDLE);
    assign ram_wr_addr = buf_idx;
    assign ram_wr_data = cmd_reg;
    assign ram_rd_addr = next_idx;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        head_idx_next  = head_idx_reg;
        valid_next     = valid_reg;
        res_load       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        result.kind    = srb_pkg::KIND_REJECTED;
        result.command = '0;
        result.seq     = seq_reg;
        result.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (reject)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (diff != '0)
                    begin
                        // early arrival: park it, a repeat simply overwrites
                        result.kind         = srb_pkg::KIND_BUFFERED;
                        ram_wr_en           = 1'b1;
                        valid_next[buf_idx] = 1'b1;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        result.kind    = srb_pkg::KIND_RELEASED;
                        result.command = srb_pkg::DATA_BITS'(cmd_reg);
                        result.seq     = head_reg;
                        result.last    = run_last;
                        head_next      = head_reg + 1'b1;
                        head_idx_next  = next_idx;
                        ram_rd_en      = !run_last;
                        state_next     = run_last ? ST_IDLE : ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    res_load                 = 1'b1;
                    result.kind              = srb_pkg::KIND_RELEASED;
                    result.command           = srb_pkg::DATA_BITS'(ram_rd_data);
                    result.seq               = head_reg;
                    result.last              = run_last;
                    valid_next[head_idx_reg] = 1'b0;
                    head_next                = head_reg + 1'b1;
                    head_idx_next            = next_idx;
                    ram_rd_en                = !run_last;
                    state_next               = run_last ? ST_IDLE : ST_DRAIN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            head_idx_reg <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            head_idx_reg <= head_idx_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            seq_reg <= req.seq_num;
            cmd_reg <= req.command[srb_pkg::CMD_BITS-1:0];
        end
    end

endmodule

// File: rtl/sequence_reorder_buffer.sv
// top level of the sequence reorder buffer: sequencer, slot ram and output register
// depends on srb_pkg, srb_if, srb_ram, srb_out_reg, srb_seq_ctrl
//
// Commands tagged with a 64-bit sequence number come in on req in any order and
// leave on rsp strictly in sequence order. Each input transaction gives one
// result on rsp for a rejected or buffered command, or a run of released
// commands when it carries the head number; the final result of every input
// has last set. A command is captured while the sequencer is idle and is classified
// in EVAL; a release hands out the head command from EVAL and each further slot of
// the run from DRAIN, fed by the registered read data of the slot ram. Slot valid
// bits live in flip-flops cleared at reset, so no clearing pass is needed after
// reset. The next transaction is taken while the last result still waits in the
// output register; a stalled rsp holds back the next classification or release,
// and with it the intake of further transactions.
module sequence_reorder_buffer (
    input  logic        clk,
    input  logic        rst_n,
    srb_in_if.sink      req,
    srb_out_if.source   rsp
);

    // handshake between sequencer and output register
    logic                          out_free;
    logic                          res_load;
    srb_pkg::result_t              result;

    // slot ram ports
    logic                          ram_wr_en;
    logic [srb_pkg::IDX_BITS-1:0]  ram_wr_addr;
    logic [srb_pkg::CMD_BITS-1:0]  ram_wr_data;
    logic                          ram_rd_en;
    logic [srb_pkg::IDX_BITS-1:0]  ram_rd_addr;
    logic [srb_pkg::CMD_BITS-1:0]  ram_rd_data;

    // head counter, valid bits and release sequencing
    srb_seq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .out_free    (out_free),
        .res_load    (res_load),
        .result      (result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // early-arrival command words, indexed by sequence number modulo depth
    srb_ram #(
        .WIDTH (srb_pkg::CMD_BITS),
        .DEPTH (srb_pkg::WINDOW_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // one-deep result register, decouples the sink from the sequencer
    srb_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .result   (result),
        .out_free (out_free),
        .rsp      (rsp)
    );

endmodule

// File: tb/srb_order_checker.sv
// checker for the sequence reorder buffer: predicts in-order release and compares results
// depends on srb_pkg; sits beside the block in sequence_reorder_buffer_test
module srb_order_checker
    import srb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_seq,
    input  logic [DATA_BITS-1:0] in_command,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           out_kind,
    input  logic [DATA_BITS-1:0] out_command,
    input  logic [DATA_BITS-1:0] out_seq,
    input  logic                 out_last,
    output int                   mismatches,
    output int                   pending,
    output logic [DATA_BITS-1:0] due_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_BITS-1:0] CMD_MASK = (CMD_BITS >= DATA_BITS) ? {DATA_BITS{1'b1}} :
                                                ((DATA_BITS'(1) << CMD_BITS) - DATA_BITS'(1));

    result_t              awaited[$];
    logic [DATA_BITS-1:0] held_cmd [WINDOW_DEPTH];
    logic                 held_vld [WINDOW_DEPTH];

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic result_t make_result(input kind_t k, input logic [DATA_BITS-1:0] c,
                                            input logic [DATA_BITS-1:0] s, input logic l);
        result_t r;
        r.kind    = k;
        r.command = c;
        r.seq     = s;
        r.last    = l;
        return r;
    endfunction

    // works out the results of one accepted command and updates the window
    task automatic classify_command(input logic [DATA_BITS-1:0] s,
                                    input logic [DATA_BITS-1:0] c_in);
        logic [DATA_BITS-1:0] c;
        logic [DATA_BITS-1:0] gap;
        result_t              run;
        int                   n;
        int                   nxt;
        c   = c_in & CMD_MASK;
        gap = s - due_seq;
        if (c == '0 || s < due_seq || gap >= WINDOW_DEPTH) begin
            awaited.push_back(make_result(KIND_REJECTED, '0, s, 1'b1));
        end
        else if (gap != '0) begin
            held_cmd[int'(s % WINDOW_DEPTH)] = c;
            held_vld[int'(s % WINDOW_DEPTH)] = 1'b1;
            awaited.push_back(make_result(KIND_BUFFERED, '0, s, 1'b1));
        end
        else begin
            // head arrived: release it and drain the contiguous run behind it
            run = make_result(KIND_RELEASED, c, due_seq, 1'b0);
            n   = 1;
            due_seq++;
            nxt = int'(due_seq % WINDOW_DEPTH);
            while (n < WINDOW_DEPTH && held_vld[nxt]) begin
                awaited.push_back(run);
                run           = make_result(KIND_RELEASED, held_cmd[nxt], due_seq, 1'b0);
                held_vld[nxt] = 1'b0;
                held_cmd[nxt] = '0;
                due_seq++;
                n++;
                nxt = int'(due_seq % WINDOW_DEPTH);
            end
            run.last = 1'b1;
            awaited.push_back(run);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n) begin
            due_seq    = '0;
            mismatches = 0;
            pending    = 0;
            awaited.delete();
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                held_vld[i] = 1'b0;
                held_cmd[i] = '0;
            end
        end
        else begin
            if (out_valid && out_ready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("result with nothing awaited, seq", out_seq, '0);
                end
                else begin
                    want = awaited.pop_front();
                    if (out_kind !== want.kind)
                        report_mismatch($sformatf("kind of seq %0d", want.seq),
                                        DATA_BITS'(out_kind), DATA_BITS'(want.kind));
                    if (out_command !== want.command)
                        report_mismatch($sformatf("command of seq %0d", want.seq),
                                        out_command, want.command);
                    if (out_seq !== want.seq)
                        report_mismatch("seq", out_seq, want.seq);
                    if (out_last !== want.last)
                        report_mismatch($sformatf("last of seq %0d", want.seq),
                                        DATA_BITS'(out_last), DATA_BITS'(want.last));
                end
            end
            if (in_valid && in_ready)
                classify_command(in_seq, in_command);
            pending = awaited.size();
        end
    end

endmodule

// File: tb/sequence_reorder_buffer_test.sv
// top of the sequence reorder buffer testbench: clock, reset, stimulus and verdict
// depends on srb_pkg, srb_if, sequence_reorder_buffer and srb_order_checker
module sequence_reorder_buffer_test
    import srb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // how a run of consecutive numbers is ordered on the way in
    localparam int RUN_ASCENDING  = 0;
    localparam int RUN_DESCENDING = 1;
    localparam int RUN_SHUFFLED   = 2;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction on either channel
    localparam int SETTLE_CYCLES = 16;    // wait before the verdict, after the last results have come back
    localparam int PHASE_ITEMS   = 25;
    localparam int NOISE_PCT     = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    int                   snd_idle_pct = 31;
    int                   rcv_idle_pct = 72;
    int                   phase_items;
    int                   quiet_cycles;
    int                   mismatches;
    int                   pending;
    logic [DATA_BITS-1:0] due_seq;

    srb_in_if  req ();
    srb_out_if rsp ();

    sequence_reorder_buffer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // the checker watches both channels and keeps its own view of the window;
    // its head number also steers the stimulus towards well-formed runs
    srb_order_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_seq      (req.seq_num),
        .in_command  (req.command),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_kind    (rsp.kind),
        .out_command (rsp.out_command),
        .out_seq     (rsp.out_seq),
        .out_last    (rsp.last),
        .mismatches  (mismatches),
        .pending     (pending),
        .due_seq     (due_seq)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle at the falling edge
    initial
    begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // nonzero command word, now and then all ones or a single bit
    function automatic logic [DATA_BITS-1:0] rand_command();
        logic [DATA_BITS-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = '1;
            1:       c = DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1);
            default: c = {$urandom, $urandom};
        endcase
        if (c == '0)
            c = DATA_BITS'(1);
        return c;
    endfunction

    // one transaction on req, with random idle cycles before it; called at a
    // falling edge and returns at the falling edge after acceptance, valid left high
    task automatic offer_command(input logic [DATA_BITS-1:0] s, input logic [DATA_BITS-1:0] c);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.seq_num <= s;
        req.command <= c;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        @(negedge clk);
        phase_items++;
    endtask

    // sender holds off until every awaited result has come back
    task automatic wait_for_results();
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // broken traffic mixed into the runs: zero commands, stale and far numbers,
    // and repeats that overwrite a slot or jump the head
    task automatic offer_noise(input logic [DATA_BITS-1:0] base, input int n);
        logic [DATA_BITS-1:0] s;
        logic [DATA_BITS-1:0] c;
        int                   back;
        c = rand_command();
        case ($urandom_range(0, 4))
            0: begin
                s = due_seq + $urandom_range(0, WINDOW_DEPTH - 1);
                c = '0;
            end
            1: begin
                back = $urandom_range(1, 8);
                s = (due_seq >= back) ? due_seq - back : due_seq + WINDOW_DEPTH + back;
            end
            2:       s = due_seq + WINDOW_DEPTH + $urandom_range(0, 3);
            3:       s = {$urandom, $urandom};
            default: s = base + $urandom_range(0, n - 1);
        endcase
        offer_command(s, c);
    endtask

    // a run of n consecutive numbers starting at the current head, in the given order
    task automatic offer_run(input int n, input int style);
        logic [DATA_BITS-1:0] base;
        logic [DATA_BITS-1:0] tmp;
        logic [DATA_BITS-1:0] order[$];
        int                   j;
        base = due_seq;
        for (int k = 0; k < n; k++) begin
            if (style == RUN_DESCENDING)
                order.push_front(base + k);
            else
                order.push_back(base + k);
        end
        if (style == RUN_SHUFFLED) begin
            for (int k = n - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        end
        foreach (order[k]) begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                offer_noise(base, n);
            offer_command(order[k], rand_command());
        end
    endtask

    initial
    begin
        int n;
        int pick;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.seq_num = '0;
        req.command = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, head starts at 0
        offer_command(64'd0, 64'd0);                         // zero command at the head
        offer_command('1, '1);                               // far beyond the window
        offer_command(64'd64, 64'd1);                        // first number past the window
        offer_command(64'd63, '1);                           // last number inside the window
        offer_command(64'd2, 64'h8000_0000_0000_0000);
        offer_command(64'd2, 64'h5555_5555_5555_5555);       // repeat overwrites the slot
        offer_command(64'd1, 64'd0);                         // zero command inside the window
        offer_command(64'd1, 64'd1);
        offer_command(64'd0, '1);                            // head releases 0, 1 and 2
        offer_command(64'd0, 64'd5);                         // behind the head
        offer_command(64'd2, '1);                            // behind the head
        offer_command(64'd66, 64'hAAAA_AAAA_AAAA_AAAA);      // window edge from head 3
        offer_command(64'd67, 64'd7);                        // just past it
        offer_command(64'd3, 64'h0123_4567_89AB_CDEF);       // lone release
        offer_command(64'h8000_0000_0000_0000, 64'd9);
        offer_command(64'd4, 64'hFFFF_FFFF_0000_0000);
        wait_for_results();

        // random part in three idling phases, each drained before the next
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 31;
                    rcv_idle_pct = 72;
                end
                1: begin
                    snd_idle_pct = 72;
                    rcv_idle_pct = 31;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            // a full-window run in descending order, released in one go unless noise jumps the head
            if (ph == 1)
                offer_run(WINDOW_DEPTH, RUN_DESCENDING);
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    n = $urandom_range(1, 8);
                else if (pick < 95)
                    n = $urandom_range(9, 24);
                else
                    n = $urandom_range(25, WINDOW_DEPTH - 1);
                offer_run(n, $urandom_range(RUN_ASCENDING, RUN_SHUFFLED));
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
